@@ hw/rtl/pttd_pkg.sv @@
// Shared constants and controller/datapath link types for the trial-division prime tester.
`default_nettype none
package pttd_pkg;

  localparam int WIDTH_DEF = 32;

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_step;
    logic advance;
  } pttd_cmd_t;

  typedef struct packed {
    logic lt_two;
    logic sq_over;
    logic div_last;
    logic rem_zero;
  } pttd_sts_t;

endpackage
`default_nettype wire

@@ hw/rtl/pttd_cand_if.sv @@
// Candidate input channel: valid/ready handshake with the number to test.
`default_nettype none
interface pttd_cand_if #(
  parameter int W = 32
);
  logic         valid;
  logic         ready;
  logic [W-1:0] candidate;

  modport source (output valid, output candidate, input ready);
  modport sink   (input valid, input candidate, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/pttd_res_if.sv @@
// Result channel: valid/ready handshake with the primality verdict.
`default_nettype none
interface pttd_res_if;
  logic valid;
  logic ready;
  logic is_prime;

  modport source (output valid, output is_prime, input ready);
  modport sink   (input valid, input is_prime, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/prime_test_trial_division.sv @@
// Top level: trial-division primality tester, controller plus datapath.
//
//   channel   dir  payload            handshake
//   cand      in   candidate[WIDTH]   valid/ready
//   result    out  is_prime           valid/ready
//
// Small candidates (0, 1, 2 and 3) are settled by the bound check with no trial
// division; otherwise each trial divisor runs the bit-serial remainder unit, one
// remainder bit per cycle, and up to about sqrt(candidate) divisors are tried.
// A new candidate is taken only in idle, after the last one has reached the
// finish state; the next is taken while the result waits.
// A stalled result holds the verdict in the finish state. rst is synchronous.
`default_nettype none
module prime_test_trial_division import pttd_pkg::*; #(
  parameter int WIDTH = WIDTH_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  pttd_cand_if.sink    cand,
  pttd_res_if.source   result
);

  pttd_cmd_t cmd;
  pttd_sts_t sts;

  pttd_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cand_valid   (cand.valid),
    .cand_ready   (cand.ready),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .res_is_prime (result.is_prime),
    .cmd          (cmd),
    .sts          (sts)
  );

  pttd_datapath #(
    .WIDTH (WIDTH)
  ) u_datapath (
    .clk       (clk),
    .candidate (cand.candidate),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
`default_nettype wire

@@ hw/rtl/pttd_datapath.sv @@
// Datapath: candidate, trial divisor, running square and bit-serial remainder unit.
`default_nettype none
module pttd_datapath import pttd_pkg::*; #(
  parameter int WIDTH = WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic [WIDTH-1:0] candidate,
  input  wire pttd_cmd_t        cmd,
  output pttd_sts_t             sts
);

  localparam int CW = $clog2(WIDTH);

  logic [WIDTH-1:0]   n;
  logic [WIDTH-1:0]   d;
  logic [WIDTH+1:0]   sq;
  logic [WIDTH-1:0]   rem;
  logic [WIDTH-1:0]   sh;
  logic [CW-1:0]      cnt;
  logic [WIDTH+1:0]   diff;
  logic [WIDTH-1:0]   rem_shift;

  assign rem_shift = {rem[WIDTH-2:0], sh[WIDTH-1]};
  assign diff      = {1'b0, rem, sh[WIDTH-1]} - {2'b00, d};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n  <= candidate;
      d  <= WIDTH'(2);
      sq <= (WIDTH+2)'(4);
    end
    if (cmd.div_start) begin
      rem <= '0;
      sh  <= n;
      cnt <= CW'(WIDTH - 1);
    end
    if (cmd.div_step) begin
      rem <= diff[WIDTH+1] ? rem_shift : diff[WIDTH-1:0];
      sh  <= {sh[WIDTH-2:0], 1'b0};
      cnt <= cnt - CW'(1);
    end
    if (cmd.advance) begin
      d  <= d + WIDTH'(1);
      sq <= sq + {1'b0, d, 1'b1};
    end
  end

  always_comb begin
    sts.lt_two   = (n < WIDTH'(2));
    sts.sq_over  = (sq > {2'b00, n});
    sts.div_last = (cnt == '0);
    sts.rem_zero = (rem == '0);
  end

endmodule
`default_nettype wire

@@ hw/rtl/pttd_ctrl.sv @@
// Controller: sequences bound check, serial division and verdict; holds the result register.
`default_nettype none
module pttd_ctrl import pttd_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  cand_valid,
  output logic       cand_ready,
  output logic       res_valid,
  input  wire logic  res_ready,
  output logic       res_is_prime,
  output pttd_cmd_t  cmd,
  input  wire pttd_sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_BOUND,
    S_DIV,
    S_TEST,
    S_FINISH
  } state_t;

  state_t state;
  logic   verdict;
  logic   res_free;

  assign res_free   = !res_valid || res_ready;
  assign cand_ready = (state == S_IDLE);

  always_comb begin
    cmd.load      = (state == S_IDLE) && cand_valid;
    cmd.div_start = (state == S_BOUND) && !sts.lt_two && !sts.sq_over;
    cmd.div_step  = (state == S_DIV);
    cmd.advance   = (state == S_TEST) && !sts.rem_zero;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      verdict   <= 1'b0;
    end else begin
      if (res_valid && res_ready && (state != S_FINISH)) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cand_valid) begin
            state <= S_BOUND;
          end
        end
        S_BOUND: begin
          if (sts.lt_two) begin
            verdict <= 1'b0;
            state   <= S_FINISH;
          end else if (sts.sq_over) begin
            verdict <= 1'b1;
            state   <= S_FINISH;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (sts.div_last) begin
            state <= S_TEST;
          end
        end
        S_TEST: begin
          if (sts.rem_zero) begin
            verdict <= 1'b0;
            state   <= S_FINISH;
          end else begin
            state <= S_BOUND;
          end
        end
        S_FINISH: begin
          if (res_free) begin
            res_valid    <= 1'b1;
            res_is_prime <= verdict;
            state        <= S_IDLE;
          end else if (res_valid && res_ready) begin
            res_valid <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ sim/prime_test_trial_division_check.sv @@
// Checker: watches both channels, predicts the primality verdict and compares results.
module prime_test_trial_division_check #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cand_valid,
  input  logic             cand_ready,
  input  logic [WIDTH-1:0] candidate,
  input  logic             res_valid,
  input  logic             res_ready,
  input  logic             is_prime,
  output int               errors,
  output int               pending
);

  typedef struct {
    logic [WIDTH-1:0] number;
    logic             verdict;
  } verdict_t;

  verdict_t verdicts_due[$];

  function automatic logic divides_only_trivially(logic [WIDTH-1:0] number);
    logic [63:0] n;
    logic [63:0] d;
    n = 64'(number);
    if (n < 64'd2) return 1'b0;
    for (d = 64'd2; d <= n / d; d++) begin
      if (n % d == 64'd0) return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    verdict_t due;
    if (rst) begin
      errors  <= 0;
      pending <= 0;
    end else begin
      if (res_valid && res_ready) begin
        if (verdicts_due.size() == 0) begin
          errors <= errors + 1;
          $display("%0t: unexpected result, expected none, actual is_prime %0b",
                   $time, is_prime);
        end else begin
          due = verdicts_due.pop_front();
          if (is_prime !== due.verdict) begin
            errors <= errors + 1;
            $display("%0t: candidate %0d expected is_prime %0b actual %0b",
                     $time, due.number, due.verdict, is_prime);
          end
        end
      end
      if (cand_valid && cand_ready) begin
        due.number  = candidate;
        due.verdict = divides_only_trivially(candidate);
        verdicts_due.push_back(due);
      end
      pending <= verdicts_due.size();
    end
  end

endmodule

@@ sim/prime_test_trial_division_test.sv @@
// Testbench top: drives candidates, stalls results, and reports the verdict.
module prime_test_trial_division_test;
  import pttd_pkg::*;

  localparam int WIDTH      = WIDTH_DEF;
  localparam int STALL_MAX  = 200000;
  localparam int RAND_ITEMS = 80;

  logic clk = 1'b0;
  logic rst;
  logic no_idle;
  int   errors;
  int   pending;
  int   quiet_cycles;

  pttd_cand_if #(.W(WIDTH)) cand ();
  pttd_res_if               result ();

  prime_test_trial_division #(.WIDTH(WIDTH)) uut (
    .clk    (clk),
    .rst    (rst),
    .cand   (cand),
    .result (result)
  );

  prime_test_trial_division_check #(.WIDTH(WIDTH)) checker_i (
    .clk        (clk),
    .rst        (rst),
    .cand_valid (cand.valid),
    .cand_ready (cand.ready),
    .candidate  (cand.candidate),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .is_prime   (result.is_prime),
    .errors     (errors),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    result.ready <= !rst && (no_idle || $urandom_range(0, 99) >= 31);
  end

  always @(posedge clk) begin
    if (rst || (cand.valid && cand.ready) || (result.valid && result.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_MAX) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic offer_candidate(input logic [WIDTH-1:0] number);
    while (!no_idle && $urandom_range(0, 99) < 31) begin
      cand.valid <= 1'b0;
      @(posedge clk);
    end
    cand.valid     <= 1'b1;
    cand.candidate <= number;
    @(posedge clk);
    while (!cand.ready) @(posedge clk);
  endtask

  task automatic drain_results();
    cand.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [WIDTH-1:0] random_candidate();
    logic [WIDTH-1:0] factor;
    case ($urandom_range(0, 3))
      0, 1:    return WIDTH'($urandom_range(0, 4095));
      2:       return WIDTH'($urandom_range(0, 262143));
      default: begin
        // multiple of a small factor, usually a large composite, keeps the divisor search short
        factor = WIDTH'($urandom_range(2, 64));
        return (WIDTH'($urandom) / factor) * factor;
      end
    endcase
  endfunction

  logic [WIDTH-1:0] directed[$];

  initial begin
    rst            <= 1'b1;
    no_idle        <= 1'b0;
    cand.valid     <= 1'b0;
    cand.candidate <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    directed = '{0, 1, 2, 3, 4, 5, 9, 25, 49, 97, 121, 63001, 65521, 1042441, 1048573,
                 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000, 32'hAAAA_AAAA,
                 32'h5555_5555, 32'h0001_0000};
    foreach (directed[i]) offer_candidate(directed[i]);
    drain_results();

    for (int i = 0; i < RAND_ITEMS; i++) begin
      no_idle <= (i >= 40 && i < 65);
      if (i == 70) drain_results();
      offer_candidate(random_candidate());
    end
    no_idle <= 1'b0;

    drain_results();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
